// File: hw/rtl/gwtp_pkg.sv
// Shared types and constants for the GEMM weight tile packer.
// Used by the controller, the datapath, the top level and the checker.
package gwtp_pkg;

  localparam int unsigned TILE_COLS_DEF = 32;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned ADDR_W     = 40;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_COUNT  = 3'd0,
    CFG_OUT_CHANNELS = 3'd1,
    CFG_IN_CHANNELS  = 3'd2,
    CFG_TILE_GAP     = 3'd3,
    CFG_BIAS_ENABLE  = 3'd4
  } cfg_idx_e;

  // Source of the next result loaded into the output register.
  typedef enum logic [1:0] {
    SEL_ITEM = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_HELD = 2'd2
  } sel_e;

  typedef struct packed {
    logic load;
    sel_e sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic pad_after;
    logic pad_before;
  } status_t;

endpackage

// File: hw/rtl/gemm_weight_tile_packer.sv
// The first write of an item is registered and valid in the cycle after the item is accepted.
// One item per cycle while the output is free, except the last bias of a partial tile
// and, without bias, the first weight of each tile, which hold off input while their
// zero pad writes (and the held weight) go out through the one-write-per-cycle output register.
// Input is held off in the cycle after a register write. Reset (rst_ni, async,
// active low) restores the register defaults and the start of the first group.
module gemm_weight_tile_packer #(
  parameter int unsigned TileCols = gwtp_pkg::TILE_COLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [gwtp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gwtp_pkg::CFG_W-1:0]           cfg_data_i,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [gwtp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value
  input  logic                                 s_axis_tuser,  // req_type
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [gwtp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // wr_offset, wr_data, pack_done
  output logic [gwtp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // wr_wide, order_error
  output logic                                 m_axis_tlast
);

  localparam int unsigned AddrW = gwtp_pkg::ADDR_W;
  localparam int unsigned DataW = gwtp_pkg::DATA_W;
  localparam int unsigned PadW  = gwtp_pkg::OUT_TDATA_W - AddrW - DataW - 1;

  gwtp_pkg::cmd_t            cmd;
  gwtp_pkg::status_t         status;
  logic [$clog2(TileCols)-1:0] pad_n;
  logic [AddrW-1:0]          wr_offset;
  logic [DataW-1:0]          wr_data;
  logic                      wr_wide, order_error, pack_done;

  gwtp_ctrl #(.TileCols(TileCols)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .status_i    (status),
    .pad_n_i     (pad_n),
    .cmd_o       (cmd)
  );

  gwtp_dpath #(.TileCols(TileCols)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_kind_i     (s_axis_tuser),
    .in_value_i    (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .pad_n_o       (pad_n),
    .wr_offset_o   (wr_offset),
    .wr_data_o     (wr_data),
    .wr_wide_o     (wr_wide),
    .order_error_o (order_error),
    .pack_done_o   (pack_done),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {PadW'(0), pack_done, wr_data, wr_offset};
  assign m_axis_tuser = {order_error, wr_wide};

endmodule

// File: hw/rtl/gwtp_ctrl.sv
// Controller of the GEMM weight tile packer: handshakes, zero-pad sequencing.
// Depends on gwtp_pkg; drives the datapath through gwtp_pkg::cmd_t.
module gwtp_ctrl #(
  parameter int unsigned TileCols = gwtp_pkg::TILE_COLS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic                    cfg_we_i,
  input  gwtp_pkg::status_t       status_i,
  input  logic [$clog2(TileCols)-1:0] pad_n_i,
  output gwtp_pkg::cmd_t          cmd_o
);

  localparam int unsigned CntW = $clog2(TileCols);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PAD  = 3'b010,
    ST_HELD = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            held_q, held_d;
  logic            valid_q, valid_d;
  logic            hold_q;
  logic            out_free;
  logic            in_ready;

  assign out_free   = !valid_q || out_ready_i;
  // Accepts stall in the cycle after a register write so the tile stride settles.
  assign in_ready   = (state_q == ST_IDLE) && out_free && !hold_q;
  assign in_ready_o = in_ready;
  assign out_valid_o = valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    cmd_o.load  = 1'b0;
    cmd_o.sel   = gwtp_pkg::SEL_ITEM;
    cmd_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_ready && in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = gwtp_pkg::SEL_ITEM;
          if (status_i.pad_after || status_i.pad_before) begin
            cmd_o.last = 1'b0;
            cnt_d      = pad_n_i;
            held_d     = status_i.pad_before;
            state_d    = ST_PAD;
          end else begin
            cmd_o.last = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = gwtp_pkg::SEL_PAD;
          cmd_o.last = (cnt_q == CntW'(1)) && !held_q;
          cnt_d      = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = held_q ? ST_HELD : ST_IDLE;
          end
        end
      end
      ST_HELD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = gwtp_pkg::SEL_HELD;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    valid_d = cmd_o.load || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      held_q  <= 1'b0;
      valid_q <= 1'b0;
      hold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      valid_q <= valid_d;
      hold_q  <= cfg_we_i;
    end
  end

endmodule

// File: hw/rtl/gwtp_dpath.sv
// Datapath of the GEMM weight tile packer: registers, layout position and offsets.
// Depends on gwtp_pkg; commanded by gwtp_ctrl.
module gwtp_dpath #(
  parameter int unsigned TileCols = gwtp_pkg::TILE_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gwtp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gwtp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_kind_i,
  input  logic [gwtp_pkg::DATA_W-1:0]    in_value_i,
  input  gwtp_pkg::cmd_t                 cmd_i,
  output gwtp_pkg::status_t              status_o,
  output logic [$clog2(TileCols)-1:0]    pad_n_o,
  output logic [gwtp_pkg::ADDR_W-1:0]    wr_offset_o,
  output logic [gwtp_pkg::DATA_W-1:0]    wr_data_o,
  output logic                           wr_wide_o,
  output logic                           order_error_o,
  output logic                           pack_done_o,
  output logic                           last_o
);

  localparam int unsigned SlotW = $clog2(TileCols);
  localparam int unsigned CfgW  = gwtp_pkg::CFG_W;
  localparam int unsigned AddrW = gwtp_pkg::ADDR_W;
  localparam int unsigned DataW = gwtp_pkg::DATA_W;
  localparam int unsigned WgtW  = gwtp_pkg::WEIGHT_W;
  localparam int unsigned CfgMax = (1 << CfgW) - 1;
  localparam int unsigned ColW  = $clog2(2 * TileCols * CfgMax + 1);
  // Tile stride and in-tile weight offset both fit in OffW bits.
  localparam int unsigned OffW  = $clog2(TileCols * 4 + TileCols * 2 * CfgMax + CfgMax + 1);

  // Configuration registers.
  logic [CfgW-1:0] grp_cnt_q, out_ch_q, in_ch_q, gap_q;
  logic            bias_en_q;

  // Layout position.
  logic             phase_q, phase_d;
  logic [CfgW-1:0]  grp_q, grp_d, row_q, row_d, col_q, col_d;
  logic [ColW-1:0]  col_off_q, col_off_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [AddrW-1:0] tile_base_q, tile_base_d, group_base_q, group_base_d;
  logic [OffW-1:0]  stride_q, stride_d;

  // Pad sequencing and the weight held back behind zero bias writes.
  logic [AddrW-1:0] pad_addr_q, pad_addr_d;
  logic [AddrW-1:0] held_off_q;
  logic [WgtW-1:0]  held_data_q;
  logic             held_done_q;

  logic [CfgW-1:0]  gc_m1, oc_m1, ic_m1, ic_eff;
  logic             err, last_row, last_col, last_grp, slot_end, done;
  logic             pad_after, pad_before, accept, restart, new_bias_en;
  logic [AddrW-1:0] bias_off, wgt_off, next_tile;
  logic [OffW-1:0]  wgt_inner;
  logic [SlotW:0]   pad_slot;

  assign gc_m1  = (grp_cnt_q == '0) ? '0 : grp_cnt_q - CfgW'(1);
  assign oc_m1  = (out_ch_q == '0) ? '0 : out_ch_q - CfgW'(1);
  assign ic_m1  = (in_ch_q == '0) ? '0 : in_ch_q - CfgW'(1);
  assign ic_eff = (in_ch_q == '0) ? CfgW'(1) : in_ch_q;

  assign stride_d = OffW'(TileCols * 4) + OffW'(ic_eff) * OffW'(TileCols * 2) + OffW'(gap_q);

  assign err       = in_kind_i != phase_q;
  assign last_row  = row_q >= oc_m1;
  assign last_col  = col_q >= ic_m1;
  assign last_grp  = grp_q >= gc_m1;
  assign slot_end  = slot_q == SlotW'(TileCols - 1);
  assign done      = phase_q && last_col && last_row && last_grp;
  assign pad_after  = !err && !phase_q && last_row && !slot_end;
  assign pad_before = !err && phase_q && !bias_en_q && (slot_q == '0) && (col_q == '0);

  assign status_o.pad_after  = pad_after;
  assign status_o.pad_before = pad_before;
  assign pad_n_o = pad_before ? SlotW'(TileCols - 1) : SlotW'(TileCols - 1) - slot_q;

  assign bias_off  = tile_base_q + AddrW'({slot_q, 2'b00});
  assign wgt_inner = OffW'(TileCols * 4) + OffW'(col_off_q) + OffW'({slot_q, 1'b0});
  assign wgt_off   = tile_base_q + AddrW'(wgt_inner);
  assign next_tile = tile_base_q + AddrW'(stride_q);
  assign pad_slot  = pad_before ? (SlotW + 1)'(1) : (SlotW + 1)'(slot_q) + (SlotW + 1)'(1);

  assign accept  = cmd_i.load && (cmd_i.sel == gwtp_pkg::SEL_ITEM) && !err;
  assign restart = cfg_we_i && (cfg_idx_i <= gwtp_pkg::CFG_BIAS_ENABLE);
  assign new_bias_en = (cfg_idx_i == gwtp_pkg::CFG_BIAS_ENABLE) ? cfg_data_i[0] : bias_en_q;

  always_comb begin
    phase_d      = phase_q;
    grp_d        = grp_q;
    row_d        = row_q;
    col_d        = col_q;
    col_off_d    = col_off_q;
    slot_d       = slot_q;
    tile_base_d  = tile_base_q;
    group_base_d = group_base_q;
    pad_addr_d   = pad_addr_q;
    if (restart) begin
      phase_d      = !new_bias_en;
      grp_d        = '0;
      row_d        = '0;
      col_d        = '0;
      col_off_d    = '0;
      slot_d       = '0;
      tile_base_d  = '0;
      group_base_d = '0;
    end else if (accept) begin
      pad_addr_d = tile_base_q + AddrW'({pad_slot, 2'b00});
      if (!phase_q) begin
        if (last_row) begin
          // Bias of the group done: weights restart at the group's first tile.
          phase_d     = 1'b1;
          row_d       = '0;
          col_d       = '0;
          col_off_d   = '0;
          slot_d      = '0;
          tile_base_d = group_base_q;
        end else begin
          row_d  = row_q + CfgW'(1);
          slot_d = slot_end ? '0 : slot_q + SlotW'(1);
          if (slot_end) begin
            tile_base_d = next_tile;
          end
        end
      end else if (!last_col) begin
        col_d     = col_q + CfgW'(1);
        col_off_d = col_off_q + ColW'(TileCols * 2);
      end else begin
        col_d     = '0;
        col_off_d = '0;
        if (!last_row) begin
          row_d  = row_q + CfgW'(1);
          slot_d = slot_end ? '0 : slot_q + SlotW'(1);
          if (slot_end) begin
            tile_base_d = next_tile;
          end
        end else if (last_grp) begin
          phase_d      = !bias_en_q;
          grp_d        = '0;
          row_d        = '0;
          slot_d       = '0;
          tile_base_d  = '0;
          group_base_d = '0;
        end else begin
          group_base_d = next_tile;
          tile_base_d  = next_tile;
          grp_d        = grp_q + CfgW'(1);
          row_d        = '0;
          slot_d       = '0;
          phase_d      = !bias_en_q;
        end
      end
    end else if (cmd_i.load && (cmd_i.sel == gwtp_pkg::SEL_PAD)) begin
      pad_addr_d = pad_addr_q + AddrW'(4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q    <= CfgW'(1);
      out_ch_q     <= CfgW'(1);
      in_ch_q      <= CfgW'(1);
      gap_q        <= '0;
      bias_en_q    <= 1'b1;
      phase_q      <= 1'b0;
      grp_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      col_off_q    <= '0;
      slot_q       <= '0;
      tile_base_q  <= '0;
      group_base_q <= '0;
      stride_q     <= OffW'(TileCols * 6);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gwtp_pkg::CFG_GROUP_COUNT:  grp_cnt_q <= cfg_data_i;
          gwtp_pkg::CFG_OUT_CHANNELS: out_ch_q  <= cfg_data_i;
          gwtp_pkg::CFG_IN_CHANNELS:  in_ch_q   <= cfg_data_i;
          gwtp_pkg::CFG_TILE_GAP:     gap_q     <= cfg_data_i;
          gwtp_pkg::CFG_BIAS_ENABLE:  bias_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      grp_q        <= grp_d;
      row_q        <= row_d;
      col_q        <= col_d;
      col_off_q    <= col_off_d;
      slot_q       <= slot_d;
      tile_base_q  <= tile_base_d;
      group_base_q <= group_base_d;
      stride_q     <= stride_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pad_addr_q <= pad_addr_d;
    if (accept && pad_before) begin
      held_off_q  <= wgt_off;
      held_data_q <= in_value_i[WgtW-1:0];
      held_done_q <= done;
    end
    if (cmd_i.load) begin
      last_o <= cmd_i.last;
      unique case (cmd_i.sel)
        gwtp_pkg::SEL_ITEM: begin
          if (err) begin
            wr_offset_o   <= '0;
            wr_data_o     <= '0;
            wr_wide_o     <= 1'b0;
            order_error_o <= 1'b1;
            pack_done_o   <= 1'b0;
          end else if (!phase_q) begin
            wr_offset_o   <= bias_off;
            wr_data_o     <= in_value_i;
            wr_wide_o     <= 1'b1;
            order_error_o <= 1'b0;
            pack_done_o   <= 1'b0;
          end else if (pad_before) begin
            // First zero bias slot of the tile; the weight follows the pads.
            wr_offset_o   <= tile_base_q;
            wr_data_o     <= '0;
            wr_wide_o     <= 1'b1;
            order_error_o <= 1'b0;
            pack_done_o   <= 1'b0;
          end else begin
            wr_offset_o   <= wgt_off;
            wr_data_o     <= DataW'(in_value_i[WgtW-1:0]);
            wr_wide_o     <= 1'b0;
            order_error_o <= 1'b0;
            pack_done_o   <= done;
          end
        end
        gwtp_pkg::SEL_PAD: begin
          wr_offset_o   <= pad_addr_q;
          wr_data_o     <= '0;
          wr_wide_o     <= 1'b1;
          order_error_o <= 1'b0;
          pack_done_o   <= 1'b0;
        end
        gwtp_pkg::SEL_HELD: begin
          wr_offset_o   <= held_off_q;
          wr_data_o     <= DataW'(held_data_q);
          wr_wide_o     <= 1'b0;
          order_error_o <= 1'b0;
          pack_done_o   <= held_done_q;
        end
        default: begin
          wr_offset_o   <= '0;
          wr_data_o     <= '0;
          wr_wide_o     <= 1'b0;
          order_error_o <= 1'b0;
          pack_done_o   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/gwtp_checker.sv
// Port-level checks for the GEMM weight tile packer, bound to the top level.
// Depends on gwtp_pkg for port widths.
module gwtp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gwtp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [gwtp_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input logic                              m_axis_tlast
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A rejected item is a single empty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata[72:0] == '0))
    else $error("order error result not clean");

  // The end of the pack is always the final weight write of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[72] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("pack done on a wrong result");

  // New items are taken only when the output register can load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("item accepted with output blocked");

  // The cycle after a register write takes no item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("item accepted right after register write");

endmodule

bind gemm_weight_tile_packer gwtp_checker u_gwtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: dv/tb_gemm_weight_tile_packer.sv
// Self-checking testbench for gemm_weight_tile_packer: a clocked driver and monitor,
// a local model of the tile packing that predicts every write, and random idling.
// Depends on gwtp_pkg and the gemm_weight_tile_packer RTL.
module tb_gemm_weight_tile_packer;
  import gwtp_pkg::*;

  localparam int unsigned TC = TILE_COLS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
  localparam int unsigned LONG_STALL = 400;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [DATA_W-1:0] data;
    logic              wide;
    logic              err;
    logic              done;
    logic              last;
  } wr_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] val;
  } in_item_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_GROUP_COUNT;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // value
  logic                   s_axis_tuser = 1'b0; // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // wr_offset, wr_data, pack_done
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // wr_wide, order_error
  logic                   m_axis_tlast;

  gemm_weight_tile_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Register copies and packing position of the local model.
  logic [15:0]       grp_cnt_r, oc_r, ic_r, gap_r;
  logic              bias_en_r;
  logic              wphase;
  logic [15:0]       grp_idx, row_idx, col_idx;
  int unsigned       slot;
  logic [ADDR_W-1:0] tile_base, grp_base;

  in_item_t item_q[$];
  wr_t      exp_wr_q[$];
  int       err_cnt = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  logic     stall_req = 1'b0;
  logic     stall_done = 1'b0;
  int       stall_left = 0;
  in_item_t nxt_item;
  wr_t      got_wr, want_wr;

  function automatic int unsigned eff(logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  function automatic logic [ADDR_W-1:0] tile_stride();
    return ADDR_W'(TC * 4 + eff(ic_r) * TC * 2 + gap_r);
  endfunction

  task automatic restart_pack();
    wphase    = !bias_en_r;
    grp_idx   = '0;
    row_idx   = '0;
    col_idx   = '0;
    slot      = 0;
    tile_base = '0;
    grp_base  = '0;
  endtask

  task automatic advance_row();
    row_idx = row_idx + 16'd1;
    slot++;
    if (slot >= TC) begin
      slot = 0;
      tile_base = tile_base + tile_stride();
    end
  endtask

  task automatic push_wr(logic [ADDR_W-1:0] off, logic [DATA_W-1:0] data,
                         logic wide, logic err, logic done, logic last);
    exp_wr_q.push_back('{off: off, data: data, wide: wide, err: err, done: done, last: last});
  endtask

  // Works out the writes that one accepted item causes and moves the position on.
  task automatic pack_item(logic kind, logic [DATA_W-1:0] val);
    logic              fin;
    logic              pad;
    logic              done;
    logic [ADDR_W-1:0] off;
    done = 1'b0;
    if (kind != wphase) begin
      push_wr('0, '0, 1'b0, 1'b1, 1'b0, 1'b1);
    end else if (!wphase) begin
      fin = (int'(row_idx) + 1 >= eff(oc_r));
      pad = fin && (slot + 1 < TC);
      push_wr(tile_base + ADDR_W'(slot * 4), val, 1'b1, 1'b0, 1'b0, !pad);
      if (fin) begin
        // Unused bias slots of a partial last tile are zero filled.
        for (int unsigned i = slot + 1; i < TC; i++)
          push_wr(tile_base + ADDR_W'(i * 4), '0, 1'b1, 1'b0, 1'b0, i == TC - 1);
        wphase    = 1'b1;
        row_idx   = '0;
        col_idx   = '0;
        slot      = 0;
        tile_base = grp_base;
      end else begin
        advance_row();
      end
    end else begin
      if (!bias_en_r && slot == 0 && col_idx == 16'd0) begin
        for (int unsigned i = 0; i < TC; i++)
          push_wr(tile_base + ADDR_W'(i * 4), '0, 1'b1, 1'b0, 1'b0, 1'b0);
      end
      off = tile_base + ADDR_W'(TC * 4) + ADDR_W'((int'(col_idx) * TC + slot) * 2);
      if (int'(col_idx) + 1 < eff(ic_r)) begin
        col_idx = col_idx + 16'd1;
      end else begin
        col_idx = '0;
        if (int'(row_idx) + 1 < eff(oc_r)) begin
          advance_row();
        end else if (int'(grp_idx) + 1 >= eff(grp_cnt_r)) begin
          done = 1'b1;
          restart_pack();
        end else begin
          grp_base  = tile_base + tile_stride();
          grp_idx   = grp_idx + 16'd1;
          tile_base = grp_base;
          row_idx   = '0;
          slot      = 0;
          wphase    = !bias_en_r;
        end
      end
      push_wr(off, {16'd0, val[15:0]}, 1'b0, 1'b0, done, 1'b1);
    end
  endtask

  task automatic note_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Driver: offers queued items and feeds each accepted one to the model.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) pack_item(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt_item.val;
          s_axis_tuser  <= nxt_item.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_left    <= LONG_STALL;
      stall_done    <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: every accepted write must match the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_wr = '{off: m_axis_tdata[39:0], data: m_axis_tdata[71:40], wide: m_axis_tuser[0],
                 err: m_axis_tuser[1], done: m_axis_tdata[72], last: m_axis_tlast};
      if (exp_wr_q.size() == 0) begin
        note_mismatch($sformatf("write off=%h data=%h with none expected",
                                got_wr.off, got_wr.data));
      end else begin
        want_wr = exp_wr_q.pop_front();
        if (got_wr !== want_wr)
          note_mismatch($sformatf(
            "got off=%h data=%h wide=%b err=%b done=%b last=%b, want %h %h %b %b %b %b",
            got_wr.off, got_wr.data, got_wr.wide, got_wr.err, got_wr.done, got_wr.last,
            want_wr.off, want_wr.data, want_wr.wide, want_wr.err, want_wr.done,
            want_wr.last));
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (item_q.size() != 0 || s_axis_tvalid || exp_wr_q.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle; each one to a known register restarts packing.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_GROUP_COUNT:  grp_cnt_r = data;
      CFG_OUT_CHANNELS: oc_r      = data;
      CFG_IN_CHANNELS:  ic_r      = data;
      CFG_TILE_GAP:     gap_r     = data;
      CFG_BIAS_ENABLE:  bias_en_r = data[0];
      default: ;
    endcase
    if (idx <= CFG_BIAS_ENABLE) restart_pack();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_item(logic kind, logic [DATA_W-1:0] val);
    item_q.push_back('{kind: kind, val: val});
  endtask

  // A well-formed item now and then preceded by one of the wrong kind.
  task automatic queue_good(logic kind);
    if ($urandom_range(15) == 0) queue_item(!kind, $urandom());
    queue_item(kind, $urandom());
  endtask

  // Queues up to two whole packs for the current registers, cut off at the budget.
  task automatic queue_packs(int budget, output int sent);
    int unsigned     g;
    longint unsigned r;
    int              packs;
    sent  = 0;
    packs = 0;
    while (sent < budget && packs < 2) begin
      g = 0;
      while (g < eff(grp_cnt_r) && sent < budget) begin
        r = 0;
        while (bias_en_r && r < eff(oc_r) && sent < budget) begin
          queue_good(1'b0);
          sent++;
          r++;
        end
        r = 0;
        while (r < longint'(eff(oc_r)) * eff(ic_r) && sent < budget) begin
          queue_good(1'b1);
          sent++;
          r++;
        end
        g++;
      end
      packs++;
    end
  endtask

  initial begin
    int sent;
    int total;
    int budget;
    grp_cnt_r = 16'd1;
    oc_r      = 16'd1;
    ic_r      = 16'd1;
    gap_r     = 16'd0;
    bias_en_r = 1'b1;
    restart_pack();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: weight before bias, a padded bias, two whole packs.
    queue_item(1'b1, 32'h1234_5678);
    queue_item(1'b0, 32'hFFFF_FFFF);
    queue_item(1'b0, 32'h0000_0000);
    queue_item(1'b1, 32'hFFFF_FFFF);
    queue_item(1'b1, 32'h0000_0000);
    queue_item(1'b0, 32'h0000_0000);
    queue_item(1'b1, 32'hFFFF_0000);
    // Without bias the first weight of a tile zero fills the bias slots.
    write_reg(CFG_BIAS_ENABLE, 16'd0);
    queue_item(1'b1, 32'h0000_FFFF);
    queue_item(1'b0, 32'hA5A5_A5A5);
    // Zero sizes act as one.
    write_reg(CFG_GROUP_COUNT, 16'd0);
    write_reg(CFG_OUT_CHANNELS, 16'd0);
    write_reg(CFG_IN_CHANNELS, 16'd0);
    queue_item(1'b1, 32'h8000_0001);
    queue_item(1'b1, 32'h7FFF_FFFE);
    // Two groups with the largest tile gap.
    write_reg(CFG_TILE_GAP, 16'hFFFF);
    write_reg(CFG_OUT_CHANNELS, 16'd2);
    write_reg(CFG_IN_CHANNELS, 16'd2);
    write_reg(CFG_GROUP_COUNT, 16'd2);
    write_reg(CFG_BIAS_ENABLE, 16'd1);
    repeat (2) begin
      repeat (2) queue_item(1'b0, $urandom());
      repeat (4) queue_item(1'b1, $urandom());
    end
    // An unknown register index leaves the packing position alone.
    write_reg(CFG_UNUSED_IDX, 16'h1234);
    queue_item(1'b0, $urandom());

    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct <= (mode == 0) ? 11 : (mode == 1) ? 75 : 0;
      snk_idle_pct <= (mode == 0) ? 75 : (mode == 1) ? 11 : 0;
      total = 0;
      while (total < 140) begin
        case ($urandom_range(7))
          0:       write_reg(CFG_GROUP_COUNT, 16'd0);
          1:       write_reg(CFG_GROUP_COUNT, 16'hFFFF);
          default: write_reg(CFG_GROUP_COUNT, 16'($urandom_range(1, 3)));
        endcase
        case ($urandom_range(9))
          0:       write_reg(CFG_OUT_CHANNELS, 16'd0);
          1:       write_reg(CFG_OUT_CHANNELS, 16'hFFFF);
          2:       write_reg(CFG_OUT_CHANNELS, 16'(TC));
          3:       write_reg(CFG_OUT_CHANNELS, 16'(TC + 1));
          default: write_reg(CFG_OUT_CHANNELS, 16'($urandom_range(1, 12)));
        endcase
        case ($urandom_range(7))
          0:       write_reg(CFG_IN_CHANNELS, 16'd0);
          1:       write_reg(CFG_IN_CHANNELS, 16'hFFFF);
          default: write_reg(CFG_IN_CHANNELS, 16'($urandom_range(1, 3)));
        endcase
        write_reg(CFG_TILE_GAP, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom()));
        write_reg(CFG_BIAS_ENABLE, 16'($urandom_range(1)));
        // Hold the receiver off while the sender keeps offering items.
        if (mode == 2) stall_req <= 1'b1;
        budget = int'($urandom_range(20, 80));
        if (budget > 140 - total) budget = 140 - total;
        queue_packs(budget, sent);
        total += sent;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && exp_wr_q.size() == 0) begin
      $display("PASS gemm_weight_tile_packer");
    end else begin
      $display("FAIL gemm_weight_tile_packer");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL gemm_weight_tile_packer");
    $finish;
  end

endmodule
